FILE: hdl/crcchk_pkg.sv
// ---------------------------------------------------------------------------
// crcchk_pkg
// Shared types and constants of the CRC codeword checker.
// ---------------------------------------------------------------------------
package crcchk_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GEN_BITS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GEN_LEN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DW_EIGHT  = 2'd2;

	// Register reset values
	localparam logic [8:0] GEN_BITS_RST = 9'd19;
	localparam logic [3:0] GEN_LEN_RST  = 4'd5;

	// result_kind codes
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0] coded_byte;
		logic       final_byte;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  decoded_byte;
		logic [31:0] codeword_total;
		logic [31:0] error_total;
		logic        last_result;
	} out_item_t;

	typedef struct packed {
		logic [8:0] gen_bits;
		logic [3:0] gen_len;
		logic       dw_eight;
	} cfg_t;

	// Results of one byte, from the core to the output stage
	typedef struct packed {
		logic        has_data;
		logic [7:0]  data_byte;
		logic        has_sum;
		logic [31:0] cw_total;
		logic [31:0] err_total;
	} res_t;

endpackage

FILE: hdl/crc_codeword_checker.sv
// ---------------------------------------------------------------------------
// crc_codeword_checker
// Checks CRC codewords in a coded byte stream and unpacks their datawords.
// ---------------------------------------------------------------------------
// Path: an input transfer loads the input register; the byte is processed into
//   the result register once the output side can absorb its results.
// Throughput: one coded byte per cycle while the output is not stalled; a final
//   byte that also yields a data byte holds the input off while the summary follows.
// Reset: arst_n clears all run state and loads generator_bits 19,
//   generator_length 5 and 4-bit dataword mode.
module crc_codeword_checker import crcchk_pkg::*; #(
	parameter int MAX_GEN_LEN = 9,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  coded_valid,
	output logic                  coded_stall,
	input  in_item_t              coded_item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output out_item_t             result_item,
	input  logic                  cfg_write_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers
	cfg_t     cfg_q;

	// Input register: one byte waiting for the bit engine
	logic     valid_s1;
	in_item_t item_s1;

	logic     ready;
	logic     fire;
	logic     take;
	res_t     res;

	// A byte is processed when the output side can absorb its results; the
	// summary of a final byte may park in the held slot until the data byte
	// ahead of it has been transferred.
	assign fire        = valid_s1 && ready;
	assign coded_stall = valid_s1 && !ready;
	assign take        = coded_valid && !coded_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gen_bits <= GEN_BITS_RST;
			cfg_q.gen_len  <= GEN_LEN_RST;
			cfg_q.dw_eight <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_GEN_BITS: begin
					cfg_q.gen_bits <= cfg_data;
				end
				CFG_GEN_LEN: begin
					cfg_q.gen_len <= cfg_data[3:0];
				end
				CFG_DW_EIGHT: begin
					cfg_q.dw_eight <= cfg_data[0];
				end
				default: begin
					// unused index: write is dropped
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= coded_item;
		end
	end

	// Bit engine: header, padding skip, CRC remainder, pairing and counters
	crcchk_core #(
		.MAX_GEN_LEN (MAX_GEN_LEN),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item_s1 (item_s1),
		.fire    (fire),
		.res     (res)
	);

	// Result register with the held summary slot
	crcchk_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res          (res),
		.fire         (fire),
		.ready        (ready),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule

FILE: hdl/crcchk_core.sv
// ---------------------------------------------------------------------------
// crcchk_core
// Run state and the eight-bit unrolled CRC/unpack update for one byte.
// ---------------------------------------------------------------------------
module crcchk_core import crcchk_pkg::*; #(
	parameter int MAX_GEN_LEN = 9,
	parameter int COUNT_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  in_item_t   item_s1,
	input  logic       fire,
	output res_t       res
);

	localparam int RW_MAX    = MAX_GEN_LEN - 1;
	localparam int LEN_W     = $clog2(MAX_GEN_LEN + 1);
	localparam int CW_BITS_W = $clog2(MAX_GEN_LEN + 8);

	logic                   hdr_q, hdr_d;
	logic [7:0]             skip_q, skip_d;
	logic [RW_MAX-1:0]      rem_q, rem_d;
	logic [CW_BITS_W-1:0]   bic_q, bic_d;
	logic [7:0]             dwb_q, dwb_d;
	logic [3:0]             pnib_q, pnib_d;
	logic                   perr_q, perr_d;
	logic                   phalf_q, phalf_d;
	logic [COUNT_WIDTH-1:0] cw_q, cw_d;
	logic [COUNT_WIDTH-1:0] err_q, err_d;

	logic [7:0]             len8;
	logic [7:0]             lenc8;
	logic [LEN_W-1:0]       len_c;
	logic [LEN_W-1:0]       rw;
	logic [RW_MAX-1:0]      mask;
	logic [RW_MAX-1:0]      top_mask;
	logic [RW_MAX+8:0]      gen_wide;
	logic [RW_MAX-1:0]      gen_m;
	logic [CW_BITS_W-1:0]   dw;
	logic [CW_BITS_W-1:0]   cw_len;

	logic                   top_bit;
	logic                   cw_err;
	logic [1:0]             cw_inc;
	logic [1:0]             err_inc;
	logic                   emit;
	logic [7:0]             emit_byte;

	logic [COUNT_WIDTH:0]   cw_sum;
	logic [COUNT_WIDTH:0]   err_sum;
	logic [COUNT_WIDTH+31:0] cw_wide;
	logic [COUNT_WIDTH+31:0] err_wide;

	// Per-run decode constants from the registers
	always_comb begin
		len8 = {4'd0, cfg.gen_len};
		if (len8 < 8'd2) begin
			lenc8 = 8'd2;
		end else if (len8 > 8'(MAX_GEN_LEN)) begin
			lenc8 = 8'(MAX_GEN_LEN);
		end else begin
			lenc8 = len8;
		end
		len_c = lenc8[LEN_W-1:0];
		rw    = len_c - LEN_W'(1);
		for (int j = 0; j < RW_MAX; j++) begin
			mask[j]     = (LEN_W'(j) < rw);
			top_mask[j] = (LEN_W'(j) == (rw - LEN_W'(1)));
		end
		gen_wide = {{RW_MAX{1'b0}}, cfg.gen_bits};
		gen_m    = gen_wide[RW_MAX-1:0] & mask;
		dw       = cfg.dw_eight ? CW_BITS_W'(8) : CW_BITS_W'(4);
		cw_len   = dw + CW_BITS_W'(rw);
	end

	// Header byte loads the skip count; every later byte takes eight bit steps, MSB first
	always_comb begin
		hdr_d     = hdr_q;
		skip_d    = skip_q;
		rem_d     = rem_q;
		bic_d     = bic_q;
		dwb_d     = dwb_q;
		pnib_d    = pnib_q;
		perr_d    = perr_q;
		phalf_d   = phalf_q;
		top_bit   = 1'b0;
		cw_err    = 1'b0;
		cw_inc    = 2'd0;
		err_inc   = 2'd0;
		emit      = 1'b0;
		emit_byte = 8'd0;
		if (!hdr_q) begin
			hdr_d  = 1'b1;
			skip_d = item_s1.coded_byte;
		end else begin
			for (int i = 7; i >= 0; i--) begin
				if (skip_d != 8'd0) begin
					skip_d = skip_d - 8'd1;
				end else begin
					if (bic_d < dw) begin
						dwb_d = {dwb_d[6:0], item_s1.coded_byte[i]};
					end
					top_bit = |(rem_d & top_mask);
					rem_d   = ((rem_d << 1) | RW_MAX'(item_s1.coded_byte[i])) & mask;
					if (top_bit) begin
						rem_d = rem_d ^ gen_m;
					end
					bic_d = bic_d + CW_BITS_W'(1);
					if (bic_d >= cw_len) begin
						cw_err = |rem_d;
						if (cfg.dw_eight) begin
							cw_inc    = 2'd1;
							err_inc   = {1'b0, cw_err};
							emit      = 1'b1;
							emit_byte = dwb_d;
						end else if (!phalf_d) begin
							pnib_d  = dwb_d[3:0];
							perr_d  = cw_err;
							phalf_d = 1'b1;
						end else begin
							cw_inc    = 2'd2;
							err_inc   = {1'b0, perr_d} + {1'b0, cw_err};
							emit      = 1'b1;
							emit_byte = {pnib_d, dwb_d[3:0]};
							phalf_d   = 1'b0;
						end
						rem_d = '0;
						bic_d = '0;
						dwb_d = 8'd0;
					end
				end
			end
		end
	end

	// Saturating counters and the 32-bit summary view
	always_comb begin
		cw_sum   = {1'b0, cw_q} + (COUNT_WIDTH+1)'(cw_inc);
		err_sum  = {1'b0, err_q} + (COUNT_WIDTH+1)'(err_inc);
		cw_d     = cw_sum[COUNT_WIDTH] ? '1 : cw_sum[COUNT_WIDTH-1:0];
		err_d    = err_sum[COUNT_WIDTH] ? '1 : err_sum[COUNT_WIDTH-1:0];
		cw_wide  = {32'd0, cw_d};
		err_wide = {32'd0, err_d};

		res.has_data  = emit;
		res.data_byte = emit_byte;
		res.has_sum   = item_s1.final_byte;
		res.cw_total  = (|cw_wide[COUNT_WIDTH+31:32]) ? 32'hFFFF_FFFF : cw_wide[31:0];
		res.err_total = (|err_wide[COUNT_WIDTH+31:32]) ? 32'hFFFF_FFFF : err_wide[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q   <= 1'b0;
			skip_q  <= 8'd0;
			rem_q   <= '0;
			bic_q   <= '0;
			dwb_q   <= 8'd0;
			pnib_q  <= 4'd0;
			perr_q  <= 1'b0;
			phalf_q <= 1'b0;
			cw_q    <= '0;
			err_q   <= '0;
		end else if (fire) begin
			if (item_s1.final_byte) begin
				hdr_q   <= 1'b0;
				skip_q  <= 8'd0;
				rem_q   <= '0;
				bic_q   <= '0;
				dwb_q   <= 8'd0;
				pnib_q  <= 4'd0;
				perr_q  <= 1'b0;
				phalf_q <= 1'b0;
				cw_q    <= '0;
				err_q   <= '0;
			end else begin
				hdr_q   <= hdr_d;
				skip_q  <= skip_d;
				rem_q   <= rem_d;
				bic_q   <= bic_d;
				dwb_q   <= dwb_d;
				pnib_q  <= pnib_d;
				perr_q  <= perr_d;
				phalf_q <= phalf_d;
				cw_q    <= cw_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

FILE: hdl/crcchk_out_stage.sv
// ---------------------------------------------------------------------------
// crcchk_out_stage
// Result register plus a held summary slot for bytes that give two results.
// ---------------------------------------------------------------------------
module crcchk_out_stage import crcchk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  res_t      res,
	input  logic      fire,
	output logic      ready,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result_item
);

	logic      out_valid_q;
	out_item_t out_q;
	logic      sum_pend_q;
	out_item_t sum_q;
	logic      out_free;
	out_item_t data_item;
	out_item_t sum_item;

	assign out_free = !out_valid_q || !result_stall;
	assign ready    = out_free && !sum_pend_q;

	always_comb begin
		data_item.result_kind    = KIND_DATA;
		data_item.decoded_byte   = res.data_byte;
		data_item.codeword_total = 32'd0;
		data_item.error_total    = 32'd0;
		data_item.last_result    = 1'b0;
		sum_item.result_kind     = KIND_SUMMARY;
		sum_item.decoded_byte    = 8'd0;
		sum_item.codeword_total  = res.cw_total;
		sum_item.error_total     = res.err_total;
		sum_item.last_result     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sum_pend_q  <= 1'b0;
		end else if (out_free) begin
			if (sum_pend_q) begin
				out_valid_q <= 1'b1;
				sum_pend_q  <= 1'b0;
			end else if (fire) begin
				out_valid_q <= res.has_data || res.has_sum;
				sum_pend_q  <= res.has_data && res.has_sum;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (sum_pend_q) begin
				out_q <= sum_q;
			end else if (fire) begin
				out_q <= res.has_data ? data_item : sum_item;
			end
		end
		if (fire && res.has_data && res.has_sum) begin
			sum_q <= sum_item;
		end
	end

	assign result_valid = out_valid_q;
	assign result_item  = out_q;

	a_pend_behind_data: assert property (@(posedge clk) disable iff (!arst_n)
		sum_pend_q |-> (out_valid_q && out_q.result_kind == KIND_DATA))
		else $error("held summary without a data result ahead of it");

	a_no_fire_when_pend: assert property (@(posedge clk) disable iff (!arst_n)
		sum_pend_q |-> !fire)
		else $error("byte processed while a summary is still held");

	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.last_result == out_q.result_kind))
		else $error("last_result and result_kind disagree");

	a_data_zero_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.result_kind == KIND_DATA)
		|-> (out_q.codeword_total == 32'd0 && out_q.error_total == 32'd0))
		else $error("data result carries nonzero counts");

endmodule
